// ===== design/oasm_pkg.sv =====
// Shared constants, codes and the result record for the open-address symbol map.
// No dependencies; oasm_ctrl and open_address_symbol_map_unit import this package.
package oasm_pkg;

	localparam int unsigned DEF_TABLE_SIZE = 1024;

	localparam int unsigned OP_W     = 2;
	localparam int unsigned KEY_W    = 32;
	localparam int unsigned HASH_W   = 64;
	localparam int unsigned VAL_W    = 64;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SLOT_W   = 10;

	localparam logic [OP_W-1:0] OP_SET = 2'd0;
	localparam logic [OP_W-1:0] OP_GET = 2'd1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_UNDEF = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                present;
		logic [VAL_W-1:0]    read_value;
		logic [SLOT_W-1:0]   slot;
	} result_t;

endpackage

// ===== design/oasm_ram.sv =====
// Simple dual-port synchronous memory holding one table entry per word.
// Read data is registered. No package dependencies.
module oasm_ram #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned WIDTH = 97
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/oasm_ctrl.sv =====
// Probe sequencer: clears the table after reset, walks the perturbed probe
// sequence through the entry memory and performs set, get and presence test.
// Depends on oasm_pkg and oasm_ram.
module oasm_ctrl #(
	parameter int unsigned TABLE_SIZE = oasm_pkg::DEF_TABLE_SIZE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [oasm_pkg::OP_W-1:0]       operation,
	input  logic [oasm_pkg::KEY_W-1:0]      key_id,
	input  logic [oasm_pkg::HASH_W-1:0]     key_hash,
	input  logic [oasm_pkg::VAL_W-1:0]      new_value,
	output logic                            res_valid,
	input  logic                            res_take,
	output oasm_pkg::result_t               res
);
	import oasm_pkg::*;

	localparam int unsigned IDX_W       = $clog2(TABLE_SIZE);
	localparam int unsigned PROBE_LIMIT = 2 * TABLE_SIZE + 16;
	localparam int unsigned STEP_W      = $clog2(PROBE_LIMIT);
	localparam int unsigned CNT_W       = $clog2(TABLE_SIZE + 1);
	localparam int unsigned LOAD_W      = CNT_W + 2;
	localparam int unsigned WORD_W      = 1 + KEY_W + VAL_W;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_CHECK = 4'b0100,
		S_RESP  = 4'b1000
	} state_t;

	state_t              state_q, state_d;
	logic [IDX_W-1:0]    j_q, j_d, jn;
	logic [HASH_W-1:0]   perturb_q, perturb_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [IDX_W-1:0]    clr_q, clr_d;
	logic [OP_W-1:0]     op_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	result_t             res_q, res_d;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr, mem_raddr;
	logic [WORD_W-1:0]   mem_wdata, mem_rdata;

	logic                rd_used, hit, stop, last, over, accept;
	logic [KEY_W-1:0]    rd_key;
	logic [VAL_W-1:0]    rd_val;

	oasm_ram #(
		.DEPTH(TABLE_SIZE),
		.WIDTH(WORD_W)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign rd_used = mem_rdata[WORD_W-1];
	assign rd_key  = mem_rdata[VAL_W +: KEY_W];
	assign rd_val  = mem_rdata[VAL_W-1:0];
	assign hit     = rd_used && (rd_key == key_q);
	assign stop    = !rd_used || hit;
	assign last    = (step_q == STEP_W'(PROBE_LIMIT - 1));
	assign over    = (LOAD_W'(cnt_q) + (LOAD_W'(cnt_q) << 1)) > LOAD_W'(2 * TABLE_SIZE);
	assign jn      = (j_q << 2) + j_q + IDX_W'(1) + perturb_q[IDX_W-1:0];

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign res_valid = (state_q == S_RESP);
	assign res       = res_q;

	always_comb begin
		state_d   = state_q;
		j_d       = j_q;
		perturb_d = perturb_q;
		step_d    = step_q;
		cnt_d     = cnt_q;
		clr_d     = clr_q;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = j_q;
		mem_wdata = {1'b1, key_q, val_q};
		mem_raddr = jn;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
				clr_d     = clr_q + IDX_W'(1);
				if (clr_q == IDX_W'(TABLE_SIZE - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				mem_raddr = key_hash[IDX_W-1:0];
				if (in_valid) begin
					j_d       = key_hash[IDX_W-1:0];
					perturb_d = key_hash;
					step_d    = '0;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stop) begin
					res_d.slot       = SLOT_W'(j_q);
					res_d.present    = hit;
					res_d.read_value = '0;
					res_d.status     = ST_OK;
					case (op_q)
						OP_SET: begin
							if (hit) begin
								mem_we = 1'b1;
							end else if (over) begin
								res_d.status = ST_FULL;
							end else begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + CNT_W'(1);
							end
						end
						OP_GET: begin
							if (hit) begin
								res_d.read_value = rd_val;
							end else begin
								res_d.status = ST_UNDEF;
							end
						end
						default: begin
						end
					endcase
					state_d = S_RESP;
				end else begin
					j_d       = jn;
					perturb_d = perturb_q >> 5;
					step_d    = step_q + STEP_W'(1);
					if (last) begin
						res_d.slot       = SLOT_W'(jn);
						res_d.present    = 1'b0;
						res_d.read_value = '0;
						case (op_q)
							OP_SET:  res_d.status = ST_FULL;
							OP_GET:  res_d.status = ST_UNDEF;
							default: res_d.status = ST_OK;
						endcase
						state_d = S_RESP;
					end
				end
			end
			S_RESP: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= '0;
			clr_q   <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			clr_q   <= clr_d;
			step_q  <= step_d;
		end
	end

	always_ff @(posedge clk) begin
		j_q       <= j_d;
		perturb_q <= perturb_d;
		res_q     <= res_d;
		if (accept) begin
			op_q  <= operation;
			key_q <= key_id;
			val_q <= new_value;
		end
	end

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_CLEAR || state_q == S_CHECK))
		else $error("entry memory written outside clear or probe");

	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(LOAD_W'(cnt_q) * LOAD_W'(3)) <= LOAD_W'(2 * TABLE_SIZE + 3))
		else $error("entry count above the load limit");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q == S_CHECK) && $past(mem_we)))
		else $error("entry count changed without an insert");

	a_probe_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && !stop) |=> (step_q == $past(step_q) + STEP_W'(1)))
		else $error("probe step counter did not advance");

endmodule

// ===== design/open_address_symbol_map_unit.sv =====
// Flow: a request is taken while idle, the probed slots are checked in turn,
// and the result is held until it is loaded into the output register.
// A new request is taken only after the previous result has left the sequencer;
// the probe run is cut off after 2*TABLE_SIZE+16 probes.
// Reset: asynchronous; afterwards a clearing pass over every entry keeps
// in_ready low. TABLE_SIZE must be a power of two. Depends on oasm_pkg, oasm_ctrl.
module open_address_symbol_map_unit #(
	parameter int unsigned TABLE_SIZE = oasm_pkg::DEF_TABLE_SIZE
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [oasm_pkg::OP_W-1:0]       operation,
	input  logic [oasm_pkg::KEY_W-1:0]      key_id,
	input  logic [oasm_pkg::HASH_W-1:0]     key_hash,
	input  logic [oasm_pkg::VAL_W-1:0]      new_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [oasm_pkg::STATUS_W-1:0]   status,
	output logic                            present,
	output logic [oasm_pkg::VAL_W-1:0]      read_value,
	output logic [oasm_pkg::SLOT_W-1:0]     slot
);
	import oasm_pkg::*;

	if ((TABLE_SIZE < 4) || ((TABLE_SIZE & (TABLE_SIZE - 1)) != 0)) begin : g_size_check
		$error("TABLE_SIZE must be a power of two of at least four");
	end

	logic    res_valid, res_take;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	oasm_ctrl #(
		.TABLE_SIZE(TABLE_SIZE)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.operation(operation),
		.key_id   (key_id),
		.key_hash (key_hash),
		.new_value(new_value),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res)
	);

	assign res_take = res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_q.status;
	assign present    = out_q.present;
	assign read_value = out_q.read_value;
	assign slot       = out_q.slot;

endmodule
